/* sv/cip_pkg.sv */
// Shared types, codes and helpers for the complex integer power block.
`timescale 1ns / 1ps
`default_nettype none

package cip_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_NEG = 2'd1;
    localparam logic [1:0] STATUS_SAT      = 2'd2;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DEN_MUL,
        ST_DEN_SUM,
        ST_DIV_RE_INIT,
        ST_DIV_RE,
        ST_DIV_RE_FIN,
        ST_DIV_IM_INIT,
        ST_DIV_IM,
        ST_DIV_IM_FIN,
        ST_COPY,
        ST_LOOP,
        ST_MUL_WB,
        ST_FINISH
    } state_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_DEN,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIN,
        OP_COPY,
        OP_WB,
        OP_OUT
    } op_t;

    // Which reciprocal part the divider works on
    typedef enum logic {
        PART_RE,
        PART_IM
    } part_t;

    typedef struct packed {
        op_t   op;
        part_t part;
    } cmd_t;

    typedef struct packed {
        logic e_zero;
        logic zero_neg;
        logic neg;
        logic mul_done;
        logic div_last;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } clamp_t;

    // Saturate a 65-bit signed value to 32 bits
    function automatic clamp_t clamp32(input logic signed [64:0] v);
        clamp_t r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > 65'sd2147483647) begin
            r.val = 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end else if (v < -65'sd2147483648) begin
            r.val = 32'h8000_0000;
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/cip_ctrl.sv */
// Controller state machine for the complex integer power block.
`timescale 1ns / 1ps
`default_nettype none

module cip_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_stall,
    input  cip_pkg::sts_t   sts,
    output cip_pkg::cmd_t   cmd
);

    cip_pkg::state_t state_reg;
    cip_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cip_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != cip_pkg::ST_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = cip_pkg::OP_NONE;
        cmd.part   = cip_pkg::PART_RE;
        case (state_reg)
            cip_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = cip_pkg::OP_LOAD;
                    state_next = cip_pkg::ST_CHECK;
                end
            end
            cip_pkg::ST_CHECK:
            begin
                if (sts.e_zero || sts.zero_neg)
                    state_next = cip_pkg::ST_FINISH;
                else if (sts.neg)
                    state_next = cip_pkg::ST_DEN_MUL;
                else
                    state_next = cip_pkg::ST_LOOP;
            end
            cip_pkg::ST_DEN_MUL:
            begin
                cmd.op     = cip_pkg::OP_MUL;
                state_next = cip_pkg::ST_DEN_SUM;
            end
            cip_pkg::ST_DEN_SUM:
            begin
                cmd.op     = cip_pkg::OP_DEN;
                state_next = cip_pkg::ST_DIV_RE_INIT;
            end
            cip_pkg::ST_DIV_RE_INIT:
            begin
                cmd.op     = cip_pkg::OP_DIV_INIT;
                state_next = cip_pkg::ST_DIV_RE;
            end
            cip_pkg::ST_DIV_RE:
            begin
                cmd.op = cip_pkg::OP_DIV_STEP;
                if (sts.div_last)
                    state_next = cip_pkg::ST_DIV_RE_FIN;
            end
            cip_pkg::ST_DIV_RE_FIN:
            begin
                cmd.op     = cip_pkg::OP_DIV_FIN;
                state_next = cip_pkg::ST_DIV_IM_INIT;
            end
            cip_pkg::ST_DIV_IM_INIT:
            begin
                cmd.op     = cip_pkg::OP_DIV_INIT;
                cmd.part   = cip_pkg::PART_IM;
                state_next = cip_pkg::ST_DIV_IM;
            end
            cip_pkg::ST_DIV_IM:
            begin
                cmd.op   = cip_pkg::OP_DIV_STEP;
                cmd.part = cip_pkg::PART_IM;
                if (sts.div_last)
                    state_next = cip_pkg::ST_DIV_IM_FIN;
            end
            cip_pkg::ST_DIV_IM_FIN:
            begin
                cmd.op     = cip_pkg::OP_DIV_FIN;
                cmd.part   = cip_pkg::PART_IM;
                state_next = cip_pkg::ST_COPY;
            end
            cip_pkg::ST_COPY:
            begin
                cmd.op     = cip_pkg::OP_COPY;
                state_next = cip_pkg::ST_LOOP;
            end
            cip_pkg::ST_LOOP:
            begin
                if (sts.mul_done)
                    state_next = cip_pkg::ST_FINISH;
                else
                begin
                    cmd.op     = cip_pkg::OP_MUL;
                    state_next = cip_pkg::ST_MUL_WB;
                end
            end
            cip_pkg::ST_MUL_WB:
            begin
                cmd.op     = cip_pkg::OP_WB;
                state_next = cip_pkg::ST_LOOP;
            end
            cip_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = cip_pkg::OP_OUT;
                    state_next = cip_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cip_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/cip_dp.sv */
// Datapath: complex multiplier, reciprocal divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module cip_dp #(
    parameter int MAX_EXPONENT = 255,
    parameter int FRAC_BITS    = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  cip_pkg::cmd_t       cmd,
    output cip_pkg::sts_t       sts,
    input  wire signed [31:0]   base_re,
    input  wire signed [31:0]   base_im,
    input  wire signed [8:0]    exponent,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic signed [31:0]  result_re,
    output logic signed [31:0]  result_im,
    output logic [1:0]          status
);

    localparam int DW  = 32 + 2 * FRAC_BITS;
    localparam int DCW = $clog2(DW + 1);
    localparam int QW  = 33;
    localparam logic [16:0] MAXE = 17'(MAX_EXPONENT);

    // Operand and running-product registers
    logic signed [31:0] xr_reg, xi_reg, rr_reg, ri_reg;
    logic signed [63:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [8:0]         cnt_reg;
    logic               e_zero_reg, zero_neg_reg, neg_reg, sat_reg;

    // Divider registers
    logic [63:0]        den_reg;
    logic [63:0]        rem_reg;
    logic [DW-1:0]      dvd_reg;
    logic [QW-1:0]      quo_reg;
    logic               big_reg;
    logic               dneg_reg;
    logic [DCW-1:0]     dcnt_reg;

    // Output register
    logic               out_valid_reg;
    logic [31:0]        res_re_reg, res_im_reg;
    logic [1:0]         status_reg;

    // Load-time decode of the exponent
    logic [8:0]  emag;
    logic [8:0]  n_clamped;
    always_comb
    begin
        emag      = exponent[8] ? 9'(-exponent) : 9'(exponent);
        n_clamped = (17'(emag) > MAXE) ? MAXE[8:0] : emag;
    end

    // Complex product: sum, floor shift and saturate
    logic signed [64:0] acc_re, acc_im, sh_re, sh_im;
    cip_pkg::clamp_t    cl_re, cl_im;
    always_comb
    begin
        acc_re = {p1_reg[63], p1_reg} - {p2_reg[63], p2_reg};
        acc_im = {p3_reg[63], p3_reg} + {p4_reg[63], p4_reg};
        sh_re  = acc_re >>> FRAC_BITS;
        sh_im  = acc_im >>> FRAC_BITS;
        cl_re  = cip_pkg::clamp32(sh_re);
        cl_im  = cip_pkg::clamp32(sh_im);
    end

    // Divider operand selection and one restoring step
    logic [31:0] dmag;
    logic        dneg;
    logic [64:0] rem_sh;
    logic        ge;
    logic [63:0] rem_new;
    always_comb
    begin
        if (cmd.part == cip_pkg::PART_RE)
        begin
            dneg = xr_reg[31];
            dmag = xr_reg[31] ? 32'(-xr_reg) : 32'(xr_reg);
        end
        else
        begin
            // numerator is the negated imaginary part
            dneg = (xi_reg != 32'sd0) && !xi_reg[31];
            dmag = xi_reg[31] ? 32'(-xi_reg) : 32'(xi_reg);
        end
        rem_sh  = {rem_reg, dvd_reg[DW-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_new = ge ? 64'(rem_sh - {1'b0, den_reg}) : rem_sh[63:0];
    end

    // Quotient finish: floor for positive, negate ceiling for negative
    logic [QW:0]  qc;
    logic [31:0]  dval;
    logic         dsat;
    always_comb
    begin
        qc = {1'b0, quo_reg} + {{QW{1'b0}}, (rem_reg != 64'd0)};
        if (!dneg_reg)
        begin
            dsat = big_reg || quo_reg[QW-1] || quo_reg[31];
            dval = dsat ? 32'h7FFF_FFFF : quo_reg[31:0];
        end
        else
        begin
            dsat = big_reg || (qc > (QW+1)'(33'h1_0000_0000 >> 1));
            dval = dsat ? 32'h8000_0000 : 32'(-qc[31:0]);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            cip_pkg::OP_LOAD:
            begin
                xr_reg       <= base_re;
                xi_reg       <= base_im;
                rr_reg       <= base_re;
                ri_reg       <= base_im;
                e_zero_reg   <= (exponent == 9'sd0);
                neg_reg      <= exponent[8];
                zero_neg_reg <= exponent[8] && (base_re == 32'sd0) && (base_im == 32'sd0);
                cnt_reg      <= n_clamped - 9'd1;
                sat_reg      <= 1'b0;
            end
            cip_pkg::OP_MUL:
            begin
                p1_reg <= xr_reg * rr_reg;
                p2_reg <= xi_reg * ri_reg;
                p3_reg <= xr_reg * ri_reg;
                p4_reg <= xi_reg * rr_reg;
            end
            cip_pkg::OP_DEN:
            begin
                den_reg <= p1_reg + p2_reg;
            end
            cip_pkg::OP_DIV_INIT:
            begin
                dvd_reg  <= {dmag, {(2 * FRAC_BITS){1'b0}}};
                dneg_reg <= dneg;
                rem_reg  <= 64'd0;
                quo_reg  <= '0;
                big_reg  <= 1'b0;
                dcnt_reg <= DCW'(DW);
            end
            cip_pkg::OP_DIV_STEP:
            begin
                dvd_reg  <= {dvd_reg[DW-2:0], 1'b0};
                rem_reg  <= rem_new;
                quo_reg  <= {quo_reg[QW-2:0], ge};
                big_reg  <= big_reg | quo_reg[QW-1];
                dcnt_reg <= dcnt_reg - DCW'(1);
            end
            cip_pkg::OP_DIV_FIN:
            begin
                if (cmd.part == cip_pkg::PART_RE)
                    xr_reg <= dval;
                else
                    xi_reg <= dval;
                sat_reg <= sat_reg | dsat;
            end
            cip_pkg::OP_COPY:
            begin
                rr_reg <= xr_reg;
                ri_reg <= xi_reg;
            end
            cip_pkg::OP_WB:
            begin
                rr_reg  <= cl_re.val;
                ri_reg  <= cl_im.val;
                sat_reg <= sat_reg | cl_re.sat | cl_im.sat;
                cnt_reg <= cnt_reg - 9'd1;
            end
            default:
            begin
            end
        endcase
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == cip_pkg::OP_OUT)
        begin
            if (e_zero_reg)
            begin
                res_re_reg <= 32'd1 << FRAC_BITS;
                res_im_reg <= 32'd0;
                status_reg <= cip_pkg::STATUS_OK;
            end
            else if (zero_neg_reg)
            begin
                res_re_reg <= 32'h7FFF_FFFF;
                res_im_reg <= 32'd0;
                status_reg <= cip_pkg::STATUS_ZERO_NEG;
            end
            else
            begin
                res_re_reg <= rr_reg;
                res_im_reg <= ri_reg;
                status_reg <= sat_reg ? cip_pkg::STATUS_SAT : cip_pkg::STATUS_OK;
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == cip_pkg::OP_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_re = res_re_reg;
    assign result_im = res_im_reg;
    assign status    = status_reg;

    // Status to the controller
    always_comb
    begin
        sts.e_zero   = e_zero_reg;
        sts.zero_neg = zero_neg_reg;
        sts.neg      = neg_reg;
        sts.mul_done = (cnt_reg == 9'd0);
        sts.div_last = (dcnt_reg == DCW'(1));
        sts.out_free = !out_valid_reg || !out_stall;
    end

endmodule

`default_nettype wire

/* sv/complex_integer_power_top.sv */
// Top level of the complex integer power block.
//
// Raises a signed fixed-point complex base to a signed integer exponent, one
// item at a time. Exponent n (clamped to MAX_EXPONENT) needs n-1 complex
// multiplies through the four shared multipliers and their writeback register.
// A negative exponent adds the reciprocal: two restoring divisions of
// 32+2*FRAC_BITS steps each on one divider. Exponent zero and a zero base
// with a negative exponent go straight to the output. A finished result waits
// in the output register; the next item is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module complex_integer_power_top #(
    parameter int MAX_EXPONENT = 255,
    parameter int FRAC_BITS    = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire signed [31:0]   base_re,
    input  wire signed [31:0]   base_im,
    input  wire signed [8:0]    exponent,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic signed [31:0]  result_re,
    output logic signed [31:0]  result_im,
    output logic [1:0]          status
);

    cip_pkg::cmd_t cmd;
    cip_pkg::sts_t sts;

    // Sequencer
    cip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic and output register
    cip_dp #(
        .MAX_EXPONENT (MAX_EXPONENT),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .base_re   (base_re),
        .base_im   (base_im),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result_re (result_re),
        .result_im (result_im),
        .status    (status)
    );

endmodule

`default_nettype wire

/* sv/cip_checker.sv */
// Port-level checker for the complex integer power block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module cip_checker (
    input wire         clk,
    input wire         rst_n,
    input wire         in_valid,
    input wire         in_stall,
    input wire         out_valid,
    input wire         out_stall,
    input wire [31:0]  result_re,
    input wire [31:0]  result_im,
    input wire [1:0]   status
);

    // A held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Status code three is never produced
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("illegal status code");

    // Zero base with negative exponent gives the fixed result
    a_zero_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cip_pkg::STATUS_ZERO_NEG
        |-> result_re == 32'h7FFF_FFFF && result_im == 32'd0)
        else $error("wrong result for zero base");

    // The block is busy the cycle after taking a transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transfer taken while busy");

endmodule

bind complex_integer_power_top cip_checker u_cip_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result_re (result_re),
    .result_im (result_im),
    .status    (status)
);

`default_nettype wire

/* verif/tb_complex_integer_power_top.sv */
// Self-checking testbench for the complex integer power block.
`timescale 1ns / 1ps

module tb_complex_integer_power_top;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic signed [8:0]  e;
    } power_req_t;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [1:0]         st;
    } power_res_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] base_re;
    logic signed [31:0] base_im;
    logic signed [8:0]  exponent;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result_re;
    logic signed [31:0] result_im;
    logic [1:0]         status;

    power_req_t pending_reqs[$];
    power_res_t expected_powers[$];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         mismatches;
    int         results_seen;
    int         hold_left;
    bit         hold_done;

    complex_integer_power_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .base_re(base_re), .base_im(base_im), .exponent(exponent),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_re(result_re), .result_im(result_im), .status(status)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Saturate a wide value to 32 bits, noting any clamp
    function automatic logic signed [31:0] sat32(input logic signed [127:0] v,
                                                  inout bit sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // floor(num * 2^32 / den), saturated
    function automatic logic signed [31:0] recip_part(input logic signed [127:0] num,
                                                       input logic signed [127:0] den,
                                                       inout bit sat);
        logic signed [127:0] n;
        logic signed [127:0] q;
        n = num <<< 32;
        q = n / den;
        if (n < 0 && q * den != n)
            q = q - 1;
        return sat32(q, sat);
    endfunction

    // Expected result of raising the base to the exponent
    function automatic power_res_t complex_power(input power_req_t r);
        power_res_t          res;
        logic signed [127:0] a, b, xr, xi, pr, pi, re, im;
        int                  n;
        bit                  sat;
        sat = 1'b0;
        a = r.re;
        b = r.im;
        n = (r.e < 0) ? -int'(r.e) : int'(r.e);
        if (n > 255)
            n = 255;
        res.st = cip_pkg::STATUS_OK;
        if (r.e == 0) begin
            res.re = 32'h0001_0000;
            res.im = 0;
        end else if (r.e < 0 && a == 0 && b == 0) begin
            res.re = 32'h7FFF_FFFF;
            res.im = 0;
            res.st = cip_pkg::STATUS_ZERO_NEG;
        end else begin
            if (r.e < 0) begin
                xr = recip_part(a, a * a + b * b, sat);
                xi = recip_part(-b, a * a + b * b, sat);
            end else begin
                xr = a;
                xi = b;
            end
            pr = xr;
            pi = xi;
            for (int k = 2; k <= n; k++) begin
                re = (xr * pr - xi * pi) >>> 16;
                im = (xr * pi + xi * pr) >>> 16;
                pr = sat32(re, sat);
                pi = sat32(im, sat);
            end
            res.re = pr[31:0];
            res.im = pi[31:0];
            if (sat)
                res.st = cip_pkg::STATUS_SAT;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] rand_part(input int mode);
        case (mode)
            0: return $signed($urandom_range(32'h30000)) - 32'sh18000;
            1: return $urandom;
            default: return ($urandom_range(1) ? 32'sh10000 : -32'sh10000)
                            + $signed($urandom_range(32'h800)) - 32'sh400;
        endcase
    endfunction

    task automatic add_req(input logic signed [31:0] re, input logic signed [31:0] im,
                           input logic signed [8:0] e);
        power_req_t r;
        r.re = re;
        r.im = im;
        r.e  = e;
        pending_reqs.push_back(r);
    endtask

    // Driver: offer queued items, hold while stalled
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            base_re  <= '0;
            base_im  <= '0;
            exponent <= '0;
        end else if (!(in_valid && in_stall)) begin
            if (in_valid)
                expected_powers.push_back(complex_power('{base_re, base_im, exponent}));
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                power_req_t r;
                r = pending_reqs.pop_front();
                in_valid <= 1'b1;
                base_re  <= r.re;
                base_im  <= r.im;
                exponent <= r.e;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer, drive stall
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_powers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result re=%h im=%h st=%0d",
                                 result_re, result_im, status);
                end else begin
                    power_res_t x;
                    x = expected_powers.pop_front();
                    if (x.re !== result_re || x.im !== result_im || x.st !== status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp re=%h im=%h st=%0d got re=%h im=%h st=%0d",
                                     x.re, x.im, x.st, result_re, result_im, status);
                    end
                end
            end
            // long hold-off once, so the block backs up
            if (!hold_done && results_seen == 300) begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Stimulus and phases
    initial begin
        int mode;
        logic signed [8:0] e;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        results_seen   = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        rst_n          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        add_req(0, 0, 0);
        add_req(0, 0, -1);
        add_req(0, 0, -256);
        add_req(0, 0, 1);
        add_req(32'sh10000, 0, 255);
        add_req(32'sh10000, 0, -256);
        add_req(32'sh20000, 0, 40);
        add_req(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1);
        add_req(32'sh80000000, 32'sh80000000, 2);
        add_req(32'sh80000000, 0, -1);
        add_req(1, 0, -1);
        add_req(0, -1, -2);
        add_req(0, 32'sh10000, 3);
        add_req(0, 32'sh20000, -3);
        add_req(32'sh0B505, 32'sh0B505, 255);
        add_req(32'sh0B505, -32'sh0B505, -255);
        add_req(32'sh7FFFFFFF, 32'sh80000000, -1);
        add_req(32'sh8000, 32'sh8000, 8);
        add_req(-32'sh10000, 0, 7);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            for (int i = 0; i < 420; i++) begin
                mode = $urandom_range(2);
                if ($urandom_range(9) < 7)
                    e = 9'($urandom_range(16)) - 9'sd8;
                else
                    e = 9'($urandom);
                add_req(rand_part(mode), rand_part(mode), e);
            end
            wait (pending_reqs.size() == 0);
        end

        @(posedge clk);
        while (in_valid || expected_powers.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
        if (mismatches == 0 && expected_powers.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Run time limit
    initial begin
        #100ms;
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/cip_pkg.sv
sv/cip_ctrl.sv
sv/cip_dp.sv
sv/complex_integer_power_top.sv
sv/cip_checker.sv
verif/tb_complex_integer_power_top.sv
